[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lsf_pkg.sv]
// ----------------------------------------------------------------------------
// lsf_pkg
// Types, codes and defaults shared by the sieve factorizer modules.
// ----------------------------------------------------------------------------
package lsf_pkg;

  // Default sizes of the factor table and the prime list.
  localparam int MAX_N_DEF      = 65535;
  localparam int MAX_PRIMES_DEF = 6542;

  // Fixed field widths of the stream items.
  localparam int VAL_W   = 16;
  localparam int COUNT_W = 13;
  localparam int EXP_W   = 5;
  localparam int STAT_W  = 2;

  // At most this many factor results per query.
  localparam int MAX_RESULTS = 6;
  localparam int K_W         = 3;

  // Item modes carried in tuser of the input channel.
  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOTABLE = 2'd2;

  // One result item.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               prime_flag;
    logic [COUNT_W-1:0] prime_count;
    logic [VAL_W-1:0]   factor_prime;
    logic [EXP_W-1:0]   factor_exponent;
    logic               last;
  } result_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_B_READ,
    ST_B_CHECK,
    ST_B_PREAD,
    ST_B_PCHK,
    ST_B_MARK,
    ST_Q_LOOK,
    ST_Q_DIV,
    ST_EMIT
  } state_t;

endpackage

[rtl/core/linear_sieve_factorizer.sv]
// ----------------------------------------------------------------------------
// linear_sieve_factorizer
// Linear sieve build of a smallest-prime-factor table, with primality test
// and factorization of queried values.
// ----------------------------------------------------------------------------
// The block handles one item at a time and holds in_tready low while it
// works. A build item first clears table entries 0..L (with L the configured
// limit clipped to MAX_N), then reads each value from 2 to L and tries the
// listed primes against it in turn, each try passing through the prime read,
// check and mark states (each composite is marked by exactly one such try),
// all on the single write port of the factor table; it answers with one
// transfer carrying the prime count. A query looks up each distinct factor
// and divides by it in the bit-serial divider, one division more than the
// factor's exponent; at most six results leave per query.
// Results pass through an output register, so the next item is taken while
// the last result still waits for the consumer.
module linear_sieve_factorizer #(
  parameter int MAX_N      = lsf_pkg::MAX_N_DEF,
  parameter int MAX_PRIMES = lsf_pkg::MAX_PRIMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // sieve_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // query_value
  input  logic        in_tuser,     // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // prime flag, prime_count, factor_prime,
                                    // factor_exponent, zero fill
  output logic [1:0]  out_tuser,    // status
  output logic        out_tlast     // last
);

  logic [lsf_pkg::VAL_W-1:0] limit_r;
  logic                      res_valid, res_ready;
  lsf_pkg::result_t          res;
  logic                      ovalid_r;
  lsf_pkg::result_t          ores_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  lsf_core #(
    .MAX_N      (MAX_N),
    .MAX_PRIMES (MAX_PRIMES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item_mode   (in_tuser),
    .item_value  (in_tdata),
    .sieve_limit (limit_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register: loads when empty or when its transfer completes.
  assign res_ready = !ovalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (res_ready) begin
      ovalid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      ores_r <= res;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ores_r.status;
  assign out_tlast  = ores_r.last;
  assign out_tdata  = {5'd0, ores_r.factor_exponent, ores_r.factor_prime,
                       ores_r.prime_count, ores_r.prime_flag};

endmodule

[rtl/core/lsf_divider.sv]
// ----------------------------------------------------------------------------
// lsf_divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsf_divider (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [lsf_pkg::VAL_W-1:0] dividend,
  input  logic [lsf_pkg::VAL_W-1:0] divisor,
  output logic                    done,
  output logic [lsf_pkg::VAL_W-1:0] quotient,
  output logic [lsf_pkg::VAL_W-1:0] remainder
);

  localparam int W   = lsf_pkg::VAL_W;
  localparam int C_W = $clog2(W);

  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [C_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] div_r, div_nxt;
  logic [W:0]   trial;
  logic [W:0]   diff;

  // One shift-and-subtract step.
  always_comb begin
    trial    = {rem_r, quo_r[W-1]};
    diff     = trial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == C_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/core/lsf_core.sv]
// ----------------------------------------------------------------------------
// lsf_core
// Sequencer with the factor table and prime list memories. Runs the linear
// sieve on a build item and walks the factor chain on a query item.
// ----------------------------------------------------------------------------
module lsf_core #(
  parameter int MAX_N      = lsf_pkg::MAX_N_DEF,
  parameter int MAX_PRIMES = lsf_pkg::MAX_PRIMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic                       item_mode,
  input  logic [lsf_pkg::VAL_W-1:0]  item_value,
  input  logic [lsf_pkg::VAL_W-1:0]  sieve_limit,
  output logic                       res_valid,
  input  logic                       res_ready,
  output lsf_pkg::result_t           res
);

  localparam int VW  = lsf_pkg::VAL_W;
  localparam int NW  = $clog2(MAX_N + 1);
  localparam int CMW = (NW > VW) ? NW : VW;
  localparam int CW  = $clog2(MAX_PRIMES + 1);
  localparam int AW  = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int KW  = lsf_pkg::K_W;

  // Memories.
  logic [NW-1:0] lft_mem [MAX_N+1];
  logic [NW-1:0] plist_mem [MAX_PRIMES];

  logic          lft_we;
  logic [NW-1:0] lft_waddr, lft_wdata, lft_raddr, lft_rdata_r;
  logic          pl_we;
  logic [AW-1:0] pl_addr;
  logic [NW-1:0] pl_wdata, pl_rdata_r;

  lsf_pkg::state_t state_r, state_nxt;

  logic [NW-1:0]   lim_r, lim_nxt;
  logic [NW-1:0]   built_r, built_nxt;
  logic            valid_r, valid_nxt;
  logic [CW-1:0]   found_r, found_nxt;
  logic [NW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [NW-1:0]   spf_r, spf_nxt;
  logic [NW-1:0]   p_r, p_nxt;
  logic [2*NW-1:0] prod_r, prod_nxt;
  logic [VW-1:0]   cur_r, cur_nxt;
  logic [VW-1:0]   fp_r, fp_nxt;
  logic [lsf_pkg::EXP_W-1:0] e_r, e_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            first_r, first_nxt;
  logic            isp_r, isp_nxt;
  lsf_pkg::result_t res_r, res_nxt;

  logic          div_start, div_done;
  logic [VW-1:0] div_a, div_b, div_q, div_rem;

  logic          lim_sat;
  logic          q_range, q_small, emit_last, i_end;

  lsf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Factor table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (lft_we) begin
      lft_mem[lft_waddr] <= lft_wdata;
    end
    lft_rdata_r <= lft_mem[lft_raddr];
  end

  // Prime list: single port with registered read.
  always_ff @(posedge clk) begin
    if (pl_we) begin
      plist_mem[pl_addr] <= pl_wdata;
    end
    pl_rdata_r <= plist_mem[pl_addr];
  end

  // Shared decode terms.
  always_comb begin
    lim_sat   = CMW'(sieve_limit) > CMW'(MAX_N);
    q_range   = CMW'(item_value) > CMW'(built_r);
    q_small   = item_value < VW'(2);
    emit_last = !((cur_r > VW'(1)) && (k_r < KW'(lsf_pkg::MAX_RESULTS - 1)));
    i_end     = (i_r == lim_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsf_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item_mode == lsf_pkg::MODE_BUILD) begin
            state_nxt = lsf_pkg::ST_CLEAR;
          end else if (!valid_r || q_range || q_small) begin
            state_nxt = lsf_pkg::ST_EMIT;
          end else begin
            state_nxt = lsf_pkg::ST_Q_LOOK;
          end
        end
      end
      lsf_pkg::ST_CLEAR: begin
        if (i_end) begin
          state_nxt = (lim_r < NW'(2)) ? lsf_pkg::ST_EMIT : lsf_pkg::ST_B_READ;
        end
      end
      lsf_pkg::ST_B_READ:  state_nxt = lsf_pkg::ST_B_CHECK;
      lsf_pkg::ST_B_CHECK: state_nxt = lsf_pkg::ST_B_PREAD;
      lsf_pkg::ST_B_PREAD: begin
        if (j_r < found_r) begin
          state_nxt = lsf_pkg::ST_B_PCHK;
        end else begin
          state_nxt = i_end ? lsf_pkg::ST_EMIT : lsf_pkg::ST_B_READ;
        end
      end
      lsf_pkg::ST_B_PCHK: state_nxt = lsf_pkg::ST_B_MARK;
      lsf_pkg::ST_B_MARK: begin
        if (prod_r > (2*NW)'(lim_r) || p_r == spf_r) begin
          state_nxt = i_end ? lsf_pkg::ST_EMIT : lsf_pkg::ST_B_READ;
        end else begin
          state_nxt = lsf_pkg::ST_B_PREAD;
        end
      end
      lsf_pkg::ST_Q_LOOK: state_nxt = lsf_pkg::ST_Q_DIV;
      lsf_pkg::ST_Q_DIV: begin
        if (div_done && div_rem != '0) begin
          state_nxt = lsf_pkg::ST_EMIT;
        end
      end
      lsf_pkg::ST_EMIT: begin
        if (res_ready) begin
          state_nxt = res_r.last ? lsf_pkg::ST_IDLE : lsf_pkg::ST_Q_LOOK;
        end
      end
      default: state_nxt = lsf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    lim_nxt   = lim_r;
    built_nxt = built_r;
    valid_nxt = valid_r;
    found_nxt = found_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    spf_nxt   = spf_r;
    p_nxt     = p_r;
    prod_nxt  = prod_r;
    cur_nxt   = cur_r;
    fp_nxt    = fp_r;
    e_nxt     = e_r;
    k_nxt     = k_r;
    first_nxt = first_r;
    isp_nxt   = isp_r;
    res_nxt   = res_r;
    lft_we    = 1'b0;
    lft_waddr = i_r;
    lft_wdata = i_r;
    lft_raddr = i_r;
    pl_we     = 1'b0;
    pl_addr   = j_r[AW-1:0];
    pl_wdata  = i_r;
    div_start = 1'b0;
    div_a     = cur_r;
    div_b     = fp_r;
    item_ready = (state_r == lsf_pkg::ST_IDLE);
    res_valid  = (state_r == lsf_pkg::ST_EMIT);

    unique case (state_r)
      lsf_pkg::ST_IDLE: begin
        lft_raddr = NW'(item_value);
        res_nxt   = '0;
        res_nxt.prime_count = lsf_pkg::COUNT_W'(found_r);
        res_nxt.last        = 1'b1;
        if (item_valid) begin
          if (item_mode == lsf_pkg::MODE_BUILD) begin
            lim_nxt = lim_sat ? NW'(MAX_N) : NW'(sieve_limit);
            i_nxt   = '0;
          end else if (!valid_r) begin
            res_nxt.status = lsf_pkg::STATUS_NOTABLE;
          end else if (q_range) begin
            res_nxt.status = lsf_pkg::STATUS_RANGE;
          end else begin
            cur_nxt   = item_value;
            k_nxt     = '0;
            first_nxt = 1'b1;
          end
        end
      end
      lsf_pkg::ST_CLEAR: begin
        lft_we    = 1'b1;
        lft_wdata = '0;
        found_nxt = '0;
        i_nxt     = i_end ? NW'(2) : i_r + 1'b1;
        if (i_end && lim_r < NW'(2)) begin
          built_nxt = lim_r;
          valid_nxt = 1'b1;
          res_nxt   = '0;
          res_nxt.last = 1'b1;
        end
      end
      lsf_pkg::ST_B_READ: begin
        lft_raddr = i_r;
      end
      lsf_pkg::ST_B_CHECK: begin
        j_nxt = '0;
        if (lft_rdata_r == '0) begin
          lft_we  = 1'b1;
          spf_nxt = i_r;
          if (found_r < CW'(MAX_PRIMES)) begin
            pl_we     = 1'b1;
            pl_addr   = found_r[AW-1:0];
            found_nxt = found_r + 1'b1;
          end
        end else begin
          spf_nxt = lft_rdata_r;
        end
      end
      lsf_pkg::ST_B_PREAD: begin
        if (j_r >= found_r) begin
          i_nxt = i_r + 1'b1;
        end
      end
      lsf_pkg::ST_B_PCHK: begin
        p_nxt    = pl_rdata_r;
        prod_nxt = i_r * pl_rdata_r;
      end
      lsf_pkg::ST_B_MARK: begin
        if (prod_r > (2*NW)'(lim_r)) begin
          i_nxt = i_r + 1'b1;
        end else begin
          lft_we    = 1'b1;
          lft_waddr = prod_r[NW-1:0];
          lft_wdata = p_r;
          if (p_r == spf_r) begin
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      lsf_pkg::ST_Q_LOOK: begin
        fp_nxt    = VW'(lft_rdata_r);
        e_nxt     = '0;
        first_nxt = 1'b0;
        if (first_r) begin
          isp_nxt = (VW'(lft_rdata_r) == cur_r);
        end
        div_start = 1'b1;
        div_b     = VW'(lft_rdata_r);
      end
      lsf_pkg::ST_Q_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            cur_nxt   = div_q;
            e_nxt     = e_r + 1'b1;
            div_start = 1'b1;
            div_a     = div_q;
          end else begin
            res_nxt.status          = lsf_pkg::STATUS_OK;
            res_nxt.prime_flag      = isp_r;
            res_nxt.prime_count     = lsf_pkg::COUNT_W'(found_r);
            res_nxt.factor_prime    = fp_r;
            res_nxt.factor_exponent = e_r;
            res_nxt.last            = emit_last;
          end
        end
      end
      lsf_pkg::ST_EMIT: begin
        lft_raddr = NW'(cur_r);
        if (res_ready) begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Close out the build once the last value has been processed.
    if (state_nxt == lsf_pkg::ST_EMIT && state_r != lsf_pkg::ST_EMIT &&
        state_r != lsf_pkg::ST_IDLE && state_r != lsf_pkg::ST_Q_DIV &&
        state_r != lsf_pkg::ST_CLEAR) begin
      built_nxt = lim_r;
      valid_nxt = 1'b1;
      res_nxt   = '0;
      res_nxt.prime_count = lsf_pkg::COUNT_W'(found_nxt);
      res_nxt.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsf_pkg::ST_IDLE;
      built_r <= '0;
      valid_r <= 1'b0;
      found_r <= '0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
      valid_r <= valid_nxt;
      found_r <= found_nxt;
    end
    lim_r   <= lim_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    spf_r   <= spf_nxt;
    p_r     <= p_nxt;
    prod_r  <= prod_nxt;
    cur_r   <= cur_nxt;
    fp_r    <= fp_nxt;
    e_r     <= e_nxt;
    k_r     <= k_nxt;
    first_r <= first_nxt;
    isp_r   <= isp_nxt;
    res_r   <= res_nxt;
  end

  assign res = res_r;

endmodule

[rtl/core/lsf_checker.sv]
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks on the factorizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // The block is busy right after taking an item.
  `ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready, "ready right after a transfer")

  // An error status always closes the item.
  `ASSERT_SAME(a_err_last, out_tvalid && out_tuser != lsf_pkg::STATUS_OK, out_tlast, "error result without last")

  // No exponent without a factor.
  `ASSERT_SAME(a_exp_zero, out_tvalid && out_tdata[29:14] == 16'd0, out_tdata[34:30] == 5'd0,
               "exponent set with no factor")

endmodule

bind linear_sieve_factorizer lsf_checker u_lsf_checker (.*);
